// File: design/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg: shared types and constants for the running median block
// Payload field types and the group size of the median selection tree.
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int MEDIAN_W   = 33;
  localparam int COUNT_W    = 9;
  // Cells folded into one register of the first selection stage
  localparam int GROUP_SIZE = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEDIAN_W-1:0] median_t;
  typedef logic        [COUNT_W-1:0]  count_field_t;

endpackage

// File: design/rms_sample_if.sv
// ----------------------------------------------------------------------------
// rms_sample_if: input channel of the running median block
// Valid/ready handshake carrying one signed sample per transaction.
// ----------------------------------------------------------------------------
interface rms_sample_if;
  import rms_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: design/rms_result_if.sv
// ----------------------------------------------------------------------------
// rms_result_if: output channel of the running median block
// Valid/ready handshake carrying the doubled median, count and drop flag.
// ----------------------------------------------------------------------------
interface rms_result_if;
  import rms_pkg::*;

  logic         valid;
  logic         ready;
  median_t      median_doubled;
  count_field_t stored_count;
  logic         dropped;

  modport source (output valid, output median_doubled, output stored_count,
                  output dropped, input ready);
  modport sink   (input valid, input median_doubled, input stored_count,
                  input dropped, output ready);
endinterface

// File: design/rms_cell.sv
// ----------------------------------------------------------------------------
// rms_cell: one entry of the sorted insertion chain
// Holds one value; on insert it either keeps it, takes the new sample or
// takes its lower neighbour's value, shifting the table up by one place.
// ----------------------------------------------------------------------------
module rms_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 9
) (
  input  logic             clk,
  input  logic             insert,
  input  rms_pkg::sample_t sample,
  input  logic [CW-1:0]    count,
  input  logic             prev_ge,
  input  rms_pkg::sample_t prev_value,
  output rms_pkg::sample_t value,
  output logic             ge
);
  import rms_pkg::*;

  logic occupied;

  // Empty cells sit above the insertion point, so they count as "moving"
  assign occupied = CW'(INDEX) < count;
  assign ge       = !occupied || (value >= sample);

  always_ff @(posedge clk) begin
    if (insert && ge) begin
      value <= prev_ge ? prev_value : sample;
    end
  end
endmodule

// File: design/rms_select_tree.sv
// ----------------------------------------------------------------------------
// rms_select_tree: picks the two middle entries out of the cell chain
// Masks each cell against the lower and upper middle index, ORs groups into
// registers, then ORs the group results.
// ----------------------------------------------------------------------------
module rms_select_tree #(
  parameter int CAPACITY = 256,
  parameter int IW       = 8
) (
  input  logic             clk,
  input  rms_pkg::sample_t values [CAPACITY],
  input  logic [IW-1:0]    lo_idx,
  input  logic [IW-1:0]    hi_idx,
  output rms_pkg::sample_t lo_val,
  output rms_pkg::sample_t hi_val
);
  import rms_pkg::*;

  localparam int NGROUP = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  sample_t group_lo [NGROUP];
  sample_t group_hi [NGROUP];

  for (genvar g = 0; g < NGROUP; g++) begin : g_group
    localparam int FIRST = g * GROUP_SIZE;
    localparam int LAST  = ((g + 1) * GROUP_SIZE < CAPACITY) ?
                           (g + 1) * GROUP_SIZE : CAPACITY;
    sample_t or_lo;
    sample_t or_hi;

    always_comb begin
      or_lo = '0;
      or_hi = '0;
      for (int k = FIRST; k < LAST; k++) begin
        if (lo_idx == IW'(k)) or_lo = or_lo | values[k];
        if (hi_idx == IW'(k)) or_hi = or_hi | values[k];
      end
    end

    always_ff @(posedge clk) begin
      group_lo[g] <= or_lo;
      group_hi[g] <= or_hi;
    end
  end

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int g = 0; g < NGROUP; g++) begin
      lo_val = lo_val | group_lo[g];
      hi_val = hi_val | group_hi[g];
    end
  end
endmodule

// File: design/running_median_sorted_insert.sv
// ----------------------------------------------------------------------------
// running_median_sorted_insert: running median over a sorted insertion chain
// Keeps every sample in ascending order and reports twice the median.
// ----------------------------------------------------------------------------
// Use: push signed 32-bit samples on the samples channel; each transaction
// produces exactly one transaction on the results channel carrying twice the
// median of all stored samples, the number stored and a drop flag.
// The table is a chain of CAPACITY cells; a sample is inserted with every
// cell comparing against it and shifting up from its neighbour.
// Once CAPACITY samples are held, further samples are dropped (dropped = 1)
// and the median of the unchanged table is reported.
// Steps: the sample is inserted into the chain, the two middle cells are
// selected in registered groups, then the final select and add form the result.
// Throughput: one sample at a time; samples.ready is high only while no item
// is in flight, so no new sample is taken until the last result has been taken.
// Stall: the result holds on the results channel until taken; no new sample
// is accepted meanwhile.
// Reset (rst, synchronous): empties the table and drops any item in flight.
// The cell contents are not cleared; cells above the fill count are unused.
// ----------------------------------------------------------------------------
module running_median_sorted_insert #(
  parameter int CAPACITY = 256
) (
  input logic          clk,
  input logic          rst,
  rms_sample_if.sink   samples,
  rms_result_if.source results
);
  import rms_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_GATHER = 2'd1;
  localparam logic [1:0] ST_REDUCE = 2'd2;
  localparam logic [1:0] ST_OUT    = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [CW-1:0]       count;
  logic [CW-1:0]       new_count;
  logic [CW-1:0]       lo_full;
  logic [CW-1:0]       hi_full;
  logic [CW+COUNT_W-1:0] count_ext;
  logic                full;
  logic                accept;
  logic                insert;
  logic [IW-1:0]       lo_idx;
  logic [IW-1:0]       hi_idx;
  logic                dropped_r;
  sample_t             lo_val;
  sample_t             hi_val;
  median_t             median;
  sample_t             cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_ge;

  assign full    = count == CW'(CAPACITY);
  assign accept  = samples.valid && samples.ready;
  assign insert  = accept && !full;

  // Count after this transaction; the middle indices follow from it
  assign new_count = full ? count : count + CW'(1);
  assign lo_full   = (new_count - CW'(1)) >> 1;
  assign hi_full   = new_count >> 1;

  // ---- insertion chain: each cell looks at its lower neighbour only ----
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      rms_cell #(.INDEX(g), .CW(CW)) u_cell (
        .clk        (clk),
        .insert     (insert),
        .sample     (samples.sample),
        .count      (count),
        .prev_ge    (1'b0),
        .prev_value (samples.sample),
        .value      (cell_value[g]),
        .ge         (cell_ge[g])
      );
    end else begin : g_rest
      rms_cell #(.INDEX(g), .CW(CW)) u_cell (
        .clk        (clk),
        .insert     (insert),
        .sample     (samples.sample),
        .count      (count),
        .prev_ge    (cell_ge[g-1]),
        .prev_value (cell_value[g-1]),
        .value      (cell_value[g]),
        .ge         (cell_ge[g])
      );
    end
  end

  // ---- middle entry selection, registered per group of cells ----
  rms_select_tree #(.CAPACITY(CAPACITY), .IW(IW)) u_select (
    .clk    (clk),
    .values (cell_value),
    .lo_idx (lo_idx),
    .hi_idx (hi_idx),
    .lo_val (lo_val),
    .hi_val (hi_val)
  );

  // ---- sequencing: insert, gather groups, reduce and add, present ----
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_GATHER;
      ST_GATHER: state_next = ST_REDUCE;
      ST_REDUCE: state_next = ST_OUT;
      ST_OUT:    if (results.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (insert) count <= count + CW'(1);
    end
  end

  // Capture the middle indices and drop flag with the transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      lo_idx    <= lo_full[IW-1:0];
      hi_idx    <= hi_full[IW-1:0];
      dropped_r <= full;
    end
    // Odd counts select the same cell twice, giving twice the middle entry
    if (state == ST_REDUCE) begin
      median <= $signed({lo_val[SAMPLE_W-1], lo_val}) +
                $signed({hi_val[SAMPLE_W-1], hi_val});
    end
  end

  // Report the count modulo the field width
  assign count_ext = {{COUNT_W{1'b0}}, count};

  assign samples.ready          = state == ST_IDLE;
  assign results.valid          = state == ST_OUT;
  assign results.median_doubled = median;
  assign results.stored_count   = count_ext[COUNT_W-1:0];
  assign results.dropped        = dropped_r;

  // ---- checks ----
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 results.valid)
    else $error("result not presented three cycles after accept");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.dropped |-> full)
    else $error("drop reported while table not full");

  a_sorted_base: assert property (@(posedge clk) disable iff (rst)
    results.valid && count >= CW'(2) |-> cell_value[0] <= cell_value[1])
    else $error("lowest two cells out of order");
endmodule

// File: test/tb_running_median_sorted_insert.sv
// ----------------------------------------------------------------------------
// tb_running_median_sorted_insert: self-checking bench for the running median
// Streams signed samples into the sorted insertion chain and compares every
// result transaction with a predicted sorted table, with gaps, stalls and a
// long hold-off on the results side.
// ----------------------------------------------------------------------------
module tb_running_median_sorted_insert;
  import rms_pkg::*;

  localparam int CAPACITY    = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  // Insert, two selection stages and the final add, plus slack
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ROUNDS = 6;
  localparam int BURST_ITEMS = 65;

  localparam sample_t SAMPLE_MIN = sample_t'(32'h8000_0000);
  localparam sample_t SAMPLE_MAX = sample_t'(32'h7FFF_FFFF);

  // One predicted result transaction
  typedef struct {
    median_t      median_doubled;
    count_field_t stored_count;
    logic         dropped;
  } median_report_t;

  logic clk = 1'b0;
  logic rst;

  rms_sample_if samples_if ();
  rms_result_if results_if ();

  running_median_sorted_insert #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if)
  );

  // Predicted contents of the chain: ascending, only the first stored_total
  // entries are meaningful.
  sample_t        sorted_store [CAPACITY];
  int             stored_total = 0;
  median_report_t pending_medians [$];

  // Idling knobs, percentages out of a hundred
  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  // Written by a test just after a rising edge, taken up by the receiver
  int hold_request = 0;
  int hold_left    = 0;

  int cycle_count     = 0;
  int error_count     = 0;
  int samples_sent    = 0;
  int results_checked = 0;
  int drops_seen      = 0;

  always #10 clk = ~clk;

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycle_count,
               pending_medians.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Place the sample in front of any equal entries, shifting the rest up
  function automatic void insert_sorted(sample_t v);
    int pos;
    int i;
    pos = 0;
    while (pos < stored_total && sorted_store[pos] < v)
      pos++;
    for (i = stored_total; i > pos; i--)
      sorted_store[i] = sorted_store[i-1];
    sorted_store[pos] = v;
    stored_total++;
  endfunction

  // Twice the median, formed at full width so the sum of two extremes is exact
  function automatic median_t doubled_middle();
    int     half;
    longint total;
    half = stored_total / 2;
    if (stored_total % 2)
      total = 2 * longint'(sorted_store[half]);
    else
      total = longint'(sorted_store[half-1]) + longint'(sorted_store[half]);
    return median_t'(total);
  endfunction

  // Advance the predicted table by one sample; a full table drops it
  function automatic median_report_t predict_median(sample_t v);
    median_report_t rep;
    rep.dropped = (stored_total >= CAPACITY);
    if (!rep.dropped)
      insert_sorted(v);
    rep.median_doubled = doubled_middle();
    rep.stored_count   = count_field_t'(stored_total);
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Results side: ready with random stalls, or held low during a hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    median_report_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      results_checked++;
      if (results_if.dropped === 1'b1)
        drops_seen++;
      if (pending_medians.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("cycle %0d: unexpected result, median %0d count %0d dropped %0b",
                   cycle_count, results_if.median_doubled, results_if.stored_count,
                   results_if.dropped);
      end else begin
        want = pending_medians.pop_front();
        if (results_if.median_doubled !== want.median_doubled ||
            results_if.stored_count !== want.stored_count ||
            results_if.dropped !== want.dropped) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("cycle %0d: mismatch, expected median %0d count %0d dropped %0b,",
                     cycle_count, want.median_doubled, want.stored_count, want.dropped);
            $display("  got median %0d count %0d dropped %0b",
                     results_if.median_doubled, results_if.stored_count,
                     results_if.dropped);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Samples side
  // ---------------------------------------------------------------------------

  // Offer one sample after a random gap and hold it until the block takes it.
  // Valid stays high on return so back-to-back samples need no extra edge.
  task automatic send_sample(sample_t v);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      samples_if.valid <= 1'b0;
      @(negedge clk);
    end
    samples_if.valid  <= 1'b1;
    samples_if.sample <= v;
    do @(posedge clk); while (samples_if.ready !== 1'b1);
    pending_medians.insert(pending_medians.size(), predict_median(v));
    samples_sent++;
  endtask

  // Mostly full-range values, with clusters near zero for equal entries and
  // runs at both ends of the range
  function automatic sample_t random_sample();
    case ($urandom_range(9))
      5, 6:    return sample_t'($urandom_range(16)) - sample_t'(8);
      7:       return $urandom_range(1) ? SAMPLE_MIN : SAMPLE_MAX;
      8:       return SAMPLE_MAX - sample_t'($urandom_range(3));
      9:       return SAMPLE_MIN + sample_t'($urandom_range(3));
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_burst(int count);
    repeat (count) send_sample(random_sample());
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic drain_results();
    @(negedge clk);
    samples_if.valid <= 1'b0;
    while (pending_medians.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes of the sample range, sums at both ends of the median field,
  // equal values and alternating bit patterns
  task automatic test_directed_extremes();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_sample(SAMPLE_MIN);            // lowest doubled median
    send_sample(SAMPLE_MIN);            // sum of two minima
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);            // minimum plus maximum
    send_sample(SAMPLE_MAX);            // highest doubled median, odd count
    send_sample(SAMPLE_MAX);            // highest doubled median, even count
    send_sample(sample_t'(0));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(1));
    send_sample(sample_t'(0));          // equal entries
    send_sample(sample_t'(0));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(32'h5555_5555));
    send_sample(sample_t'(32'hAAAA_AAAA));
    send_sample(SAMPLE_MAX - sample_t'(1));
    send_sample(SAMPLE_MIN + sample_t'(1));
    send_sample(sample_t'(32'h0000_FFFF));
    send_sample(sample_t'(32'hFFFF_0000));
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
  endtask

  task automatic test_no_idling(int count);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_burst(count);
  endtask

  task automatic test_sender_gaps(int count);
    sender_idle_pct    = 72;
    receiver_stall_pct = 0;
    send_burst(count);
  endtask

  task automatic test_receiver_stalls(int count);
    sender_idle_pct    = 0;
    receiver_stall_pct = 72;
    send_burst(count);
  endtask

  task automatic test_both_idle(int count);
    sender_idle_pct    = 6;
    receiver_stall_pct = 6;
    send_burst(count);
  endtask

  // Hold the results side off for a long stretch while samples keep coming,
  // so that the block backs up and stalls its input
  task automatic test_long_hold_off(int count);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    @(posedge clk);
    hold_request = HOLD_OFF_CYCLES;
    send_burst(count);
  endtask

  // Pause the samples side until the block has nothing left to report
  task automatic test_drain_pause();
    receiver_stall_pct = 30;
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    samples_if.valid  = 1'b0;
    samples_if.sample = '0;
    results_if.ready  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_extremes();
    test_drain_pause();

    // Cycle through the idling mixes so that insertions and, once the table
    // is full, drops both see every mix
    for (int round = 0; round < ROUNDS; round++) begin
      test_no_idling(BURST_ITEMS);
      test_sender_gaps(BURST_ITEMS);
      test_receiver_stalls(BURST_ITEMS);
      test_both_idle(BURST_ITEMS);
      if (round == 1 || round == 4)
        test_long_hold_off(20);
      if (round == 2)
        test_drain_pause();
    end

    // Let the last results out, then allow any stray transaction to show up
    receiver_stall_pct = 0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d samples, %0d results checked: table filled to %0d entries,",
             samples_sent, results_checked, stored_total);
    $display("then %0d dropped on a full table, under gaps, stalls and long hold-offs",
             drops_seen);
    if (error_count == 0 && pending_medians.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results never arrived", error_count,
               pending_medians.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
